[src/nmeafc_pkg.sv]
`default_nettype none
package nmeafc_pkg;

   // Character codes
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   // Sentence identifiers (chars 3..5)
   localparam logic [23:0] ID_RMB = 24'h524D42;
   localparam logic [23:0] ID_RMC = 24'h524D43;
   localparam logic [23:0] ID_GGA = 24'h474741;
   localparam logic [23:0] ID_VTG = 24'h565447;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_FORMAT   = 2'd2;

   // Sentence kind codes
   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_RMB   = 3'd1;
   localparam logic [2:0] KIND_RMC   = 3'd2;
   localparam logic [2:0] KIND_GGA   = 3'd3;
   localparam logic [2:0] KIND_VTG   = 3'd4;

   // Frame layout
   localparam int MIN_CHECK_LEN = 10;
   localparam int DATE_COMMAS   = 8;
   localparam int QDEPTH        = 2;

   // Frame state captured at a qualifying CR
   typedef struct packed {
      logic        star_seen;
      logic [7:0]  xor_before_star;
      logic [15:0] after_star;
      logic [23:0] type_id;
      logic [3:0]  comma_count;
      logic [31:0] time_digits;
      logic [47:0] date_digits;
   } snap_type;

   typedef struct packed {
      logic     valid;
      snap_type snap;
   } qentry_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h37;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         d = c - 8'h57;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   // (a-'0')*10 + (b-'0'), modulo 256
   function automatic logic [7:0] two_digits(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] ha;
      logic [7:0] hb;
      ha = a - CH_ZERO;
      hb = b - CH_ZERO;
      return 8'((ha << 3) + (ha << 1) + hb);
   endfunction

endpackage
`default_nettype wire

[src/nmeafc_channels.sv]
`default_nettype none
interface nmeafc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nmeafc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [2:0] sentence_kind;
   logic       time_valid;
   logic [7:0] hour;
   logic [7:0] minute;
   logic       date_valid;
   logic [7:0] day;
   logic [7:0] month;
   logic [7:0] year;
   modport source (output valid, output status, output sentence_kind, output time_valid,
                   output hour, output minute, output date_valid, output day,
                   output month, output year, input ready);
   modport sink   (input valid, input status, input sentence_kind, input time_valid,
                   input hour, input minute, input date_valid, input day,
                   input month, input year, output ready);
endinterface
`default_nettype wire

[src/nmeafc_front.sv]
`default_nettype none
module nmeafc_front #(
   parameter int MAX_SENTENCE_LEN = 128
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           rx_byte,
   output nmeafc_pkg::qentry_type    push
);

   localparam int CNT_W = $clog2(MAX_SENTENCE_LEN + 1);

   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] char_count_ff, char_count_in;
   logic [7:0]       running_xor_ff, running_xor_in;
   logic [7:0]       xor_before_star_ff, xor_before_star_in;
   logic             star_seen_ff, star_seen_in;
   logic [15:0]      after_star_ff, after_star_in;
   logic [1:0]       tail_len_ff, tail_len_in;
   logic [23:0]      type_id_ff, type_id_in;
   logic [3:0]       comma_count_ff, comma_count_in;
   logic [31:0]      time_digits_ff, time_digits_in;
   logic [47:0]      date_digits_ff, date_digits_in;
   logic [2:0]       date_len_ff, date_len_in;
   logic             clr;

   always_comb begin
      in_frame_in        = in_frame_ff;
      char_count_in      = char_count_ff;
      running_xor_in     = running_xor_ff;
      xor_before_star_in = xor_before_star_ff;
      star_seen_in       = star_seen_ff;
      after_star_in      = after_star_ff;
      tail_len_in        = tail_len_ff;
      type_id_in         = type_id_ff;
      comma_count_in     = comma_count_ff;
      time_digits_in     = time_digits_ff;
      date_digits_in     = date_digits_ff;
      date_len_in        = date_len_ff;
      clr                = 1'b0;
      push.valid         = 1'b0;
      push.snap.star_seen       = star_seen_ff;
      push.snap.xor_before_star = xor_before_star_ff;
      push.snap.after_star      = after_star_ff;
      push.snap.type_id         = type_id_ff;
      push.snap.comma_count     = comma_count_ff;
      push.snap.time_digits     = time_digits_ff;
      push.snap.date_digits     = date_digits_ff;

      if (accept) begin
         if (!in_frame_ff || rx_byte == nmeafc_pkg::CH_DOLLAR) begin
            clr = 1'b1;
            in_frame_in   = (rx_byte == nmeafc_pkg::CH_DOLLAR);
            char_count_in = (rx_byte == nmeafc_pkg::CH_DOLLAR) ? CNT_W'(1) : '0;
         end else if (rx_byte == nmeafc_pkg::CH_CR &&
                      char_count_ff < CNT_W'(nmeafc_pkg::MIN_CHECK_LEN)) begin
            clr           = 1'b1;
            in_frame_in   = 1'b0;
            char_count_in = '0;
         end else begin
            // CR with a long enough frame: report, then append the CR itself
            push.valid = (rx_byte == nmeafc_pkg::CH_CR);

            if (rx_byte == nmeafc_pkg::CH_STAR) begin
               star_seen_in       = 1'b1;
               xor_before_star_in = running_xor_ff;
               after_star_in      = '0;
               tail_len_in        = '0;
            end else if (star_seen_ff && tail_len_ff < 2'd2) begin
               if (tail_len_ff == 2'd0) begin
                  after_star_in[15:8] = rx_byte;
               end else begin
                  after_star_in[7:0] = rx_byte;
               end
               tail_len_in = tail_len_ff + 2'd1;
            end
            running_xor_in = running_xor_ff ^ rx_byte;

            if (char_count_ff >= CNT_W'(3) && char_count_ff <= CNT_W'(5)) begin
               type_id_in = {type_id_ff[15:0], rx_byte};
            end

            if (char_count_ff == CNT_W'(7)) time_digits_in[31:24] = rx_byte;
            if (char_count_ff == CNT_W'(8)) time_digits_in[23:16] = rx_byte;
            if (char_count_ff == CNT_W'(9)) time_digits_in[15:8]  = rx_byte;
            if (char_count_ff == CNT_W'(10)) time_digits_in[7:0]  = rx_byte;

            if (char_count_ff >= CNT_W'(7)) begin
               if (comma_count_ff >= 4'(nmeafc_pkg::DATE_COMMAS)) begin
                  if (date_len_ff < 3'd6) begin
                     case (date_len_ff)
                        3'd0:    date_digits_in[47:40] = rx_byte;
                        3'd1:    date_digits_in[39:32] = rx_byte;
                        3'd2:    date_digits_in[31:24] = rx_byte;
                        3'd3:    date_digits_in[23:16] = rx_byte;
                        3'd4:    date_digits_in[15:8]  = rx_byte;
                        default: date_digits_in[7:0]   = rx_byte;
                     endcase
                     date_len_in = date_len_ff + 3'd1;
                  end
               end else if (rx_byte == nmeafc_pkg::CH_COMMA) begin
                  comma_count_in = comma_count_ff + 4'd1;
               end
            end

            char_count_in = char_count_ff + CNT_W'(1);
            // length limit closes the frame
            if (char_count_ff >= CNT_W'(MAX_SENTENCE_LEN - 1)) begin
               clr           = 1'b1;
               in_frame_in   = 1'b0;
               char_count_in = '0;
            end
         end

         if (clr) begin
            running_xor_in     = '0;
            xor_before_star_in = '0;
            star_seen_in       = 1'b0;
            after_star_in      = '0;
            tail_len_in        = '0;
            type_id_in         = '0;
            comma_count_in     = '0;
            time_digits_in     = '0;
            date_digits_in     = '0;
            date_len_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff        <= 1'b0;
         char_count_ff      <= '0;
         running_xor_ff     <= '0;
         xor_before_star_ff <= '0;
         star_seen_ff       <= 1'b0;
         after_star_ff      <= '0;
         tail_len_ff        <= '0;
         type_id_ff         <= '0;
         comma_count_ff     <= '0;
         time_digits_ff     <= '0;
         date_digits_ff     <= '0;
         date_len_ff        <= '0;
      end else begin
         in_frame_ff        <= in_frame_in;
         char_count_ff      <= char_count_in;
         running_xor_ff     <= running_xor_in;
         xor_before_star_ff <= xor_before_star_in;
         star_seen_ff       <= star_seen_in;
         after_star_ff      <= after_star_in;
         tail_len_ff        <= tail_len_in;
         type_id_ff         <= type_id_in;
         comma_count_ff     <= comma_count_in;
         time_digits_ff     <= time_digits_in;
         date_digits_ff     <= date_digits_in;
         date_len_ff        <= date_len_in;
      end
   end

   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> char_count_ff == '0)
      else $error("char count nonzero outside a frame");

   a_push_on_cr: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> accept && rx_byte == nmeafc_pkg::CH_CR && in_frame_ff)
      else $error("report pushed without an in-frame CR");

   a_comma_cap: assert property (@(posedge clock) disable iff (reset)
      comma_count_ff <= 4'(nmeafc_pkg::DATE_COMMAS))
      else $error("comma count past date field");

endmodule
`default_nettype wire

[src/nmeafc_queue.sv]
`default_nettype none
module nmeafc_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire nmeafc_pkg::qentry_type push,
   input  wire logic                 pop,
   output nmeafc_pkg::qentry_type    head,
   output logic                      full
);

   localparam int PTR_W = $clog2(nmeafc_pkg::QDEPTH);
   localparam int CNT_W = $clog2(nmeafc_pkg::QDEPTH + 1);

   nmeafc_pkg::snap_type slot_ff [nmeafc_pkg::QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign do_pop     = pop && count_ff != '0;
   assign full       = count_ff == CNT_W'(nmeafc_pkg::QDEPTH);
   assign head.valid = count_ff != '0;
   assign head.snap  = slot_ff[rd_ptr_ff];
   assign count_in   = count_ff + CNT_W'(push.valid) - CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.snap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) wr_ptr_ff <= PTR_W'((32'(wr_ptr_ff) + 1) % nmeafc_pkg::QDEPTH);
         if (do_pop)     rd_ptr_ff <= PTR_W'((32'(rd_ptr_ff) + 1) % nmeafc_pkg::QDEPTH);
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.valid || do_pop)
      else $error("push into full queue");

endmodule
`default_nettype wire

[src/nmeafc_back.sv]
`default_nettype none
module nmeafc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire nmeafc_pkg::qentry_type head,
   output logic                      pop,
   nmeafc_rsp_if.source              rsp_ch
);

   logic       valid_ff;
   logic [1:0] status_ff, status_in;
   logic [2:0] kind_ff, kind_in;
   logic       tv_ff, tv_in;
   logic [7:0] hour_ff, hour_in;
   logic [7:0] minute_ff, minute_in;
   logic       dv_ff, dv_in;
   logic [7:0] day_ff, day_in;
   logic [7:0] month_ff, month_in;
   logic [7:0] year_ff, year_in;
   logic [4:0] hi, lo;
   nmeafc_pkg::snap_type s;

   assign s   = head.snap;
   assign pop = head.valid && (!valid_ff || rsp_ch.ready);
   assign hi  = nmeafc_pkg::hex_val(s.after_star[15:8]);
   assign lo  = nmeafc_pkg::hex_val(s.after_star[7:0]);

   always_comb begin
      if (!s.star_seen || !hi[4] || !lo[4]) begin
         status_in = nmeafc_pkg::ST_FORMAT;
      end else if (s.xor_before_star != {hi[3:0], lo[3:0]}) begin
         status_in = nmeafc_pkg::ST_MISMATCH;
      end else begin
         status_in = nmeafc_pkg::ST_OK;
      end

      case (s.type_id)
         nmeafc_pkg::ID_RMB: kind_in = nmeafc_pkg::KIND_RMB;
         nmeafc_pkg::ID_RMC: kind_in = nmeafc_pkg::KIND_RMC;
         nmeafc_pkg::ID_GGA: kind_in = nmeafc_pkg::KIND_GGA;
         nmeafc_pkg::ID_VTG: kind_in = nmeafc_pkg::KIND_VTG;
         default:            kind_in = nmeafc_pkg::KIND_OTHER;
      endcase

      tv_in     = 1'b0;
      hour_in   = '0;
      minute_in = '0;
      dv_in     = 1'b0;
      day_in    = '0;
      month_in  = '0;
      year_in   = '0;
      if (status_in == nmeafc_pkg::ST_OK && kind_in == nmeafc_pkg::KIND_RMC) begin
         if (s.time_digits[31:24] != nmeafc_pkg::CH_COMMA) begin
            tv_in     = 1'b1;
            hour_in   = nmeafc_pkg::two_digits(s.time_digits[31:24], s.time_digits[23:16]);
            minute_in = nmeafc_pkg::two_digits(s.time_digits[15:8], s.time_digits[7:0]);
         end
         if (s.comma_count >= 4'(nmeafc_pkg::DATE_COMMAS) &&
             s.date_digits[47:40] != nmeafc_pkg::CH_COMMA) begin
            dv_in    = 1'b1;
            day_in   = nmeafc_pkg::two_digits(s.date_digits[47:40], s.date_digits[39:32]);
            month_in = nmeafc_pkg::two_digits(s.date_digits[31:24], s.date_digits[23:16]);
            year_in  = nmeafc_pkg::two_digits(s.date_digits[15:8], s.date_digits[7:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         tv_ff     <= tv_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         dv_ff     <= dv_in;
         day_ff    <= day_in;
         month_ff  <= month_in;
         year_ff   <= year_in;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.sentence_kind = kind_ff;
   assign rsp_ch.time_valid    = tv_ff;
   assign rsp_ch.hour          = hour_ff;
   assign rsp_ch.minute        = minute_ff;
   assign rsp_ch.date_valid    = dv_ff;
   assign rsp_ch.day           = day_ff;
   assign rsp_ch.month         = month_ff;
   assign rsp_ch.year          = year_ff;

   a_time_needs_ok_rmc: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (tv_ff || dv_ff) |->
         status_ff == nmeafc_pkg::ST_OK && kind_ff == nmeafc_pkg::KIND_RMC)
      else $error("time/date flagged on a non-RMC or bad sentence");

   a_date_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !dv_ff |-> day_ff == '0 && month_ff == '0 && year_ff == '0)
      else $error("date fields nonzero without valid date");

endmodule
`default_nettype wire

[src/nmea_sentence_framer_checker.sv]
`default_nettype none
// Channel   Dir  Payload                                          Transfer
// req_ch    in   rx_byte[7:0]                                     valid && ready
// rsp_ch    out  status, sentence_kind, time_valid, hour, minute,  valid && ready
//                date_valid, day, month, year
//
// One byte per cycle while the queue is not full. Each byte updates the framer
// in the cycle it is taken; a CR in a checkable frame (ten or more characters)
// produces one result, which passes the queue and the output register to rsp_ch.
// Between framer and decoder sits a two-entry queue; req_ch.ready drops only
// when that queue is full, i.e. after two results wait behind a stalled rsp_ch.
// Reset (synchronous) clears the framer, the queue and the output valid.
module nmea_sentence_framer_checker #(
   parameter int MAX_SENTENCE_LEN = 128
) (
   input  wire logic      clock,
   input  wire logic      reset,
   nmeafc_req_if.sink     req_ch,
   nmeafc_rsp_if.source   rsp_ch
);

   nmeafc_pkg::qentry_type push;
   nmeafc_pkg::qentry_type head;
   logic                   pop;
   logic                   full;

   // Framer stalls only on a full queue
   assign req_ch.ready = !full;

   // Front: framing, running XOR, field capture
   nmeafc_front #(
      .MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_ch.valid && req_ch.ready),
      .rx_byte (req_ch.rx_byte),
      .push    (push)
   );

   // Decouples the byte stream from response backpressure
   nmeafc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   // Back: checksum verdict, classification, RMC digit decode, output register
   nmeafc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   localparam int FRAME_LIMIT = 128;      // max frame length, '$' included
   localparam int RUN_LIMIT   = 400000;   // cycle ceiling for the whole run
   localparam logic [7:0] CH_LF = 8'h0A;

   // Checksum tail variants appended to a generated sentence
   typedef enum int {CK_GOOD, CK_GOOD_LOWER, CK_WRONG, CK_NONE, CK_NONHEX, CK_SHORT} ck_mode_type;

   // One decoded sentence, as the block reports it
   typedef struct packed {
      logic [1:0] status;
      logic [2:0] kind;
      logic       time_valid;
      logic [7:0] hour;
      logic [7:0] minute;
      logic       date_valid;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
   } fix_report_type;

   // Sentence tracker: mirrors the framer byte by byte and holds the
   // reports that are still owed by the block.
   class sentence_tracker;
      fix_report_type awaited[$];
      int          errors;
      int          reports_made;
      int          counted_bytes;   // bytes that the framer acts on
      int          frame_limit;

      bit          in_frame;
      int unsigned char_count;
      logic [7:0]  run_xor;
      logic [7:0]  xor_at_star;
      bit          star_seen;
      logic [15:0] cks_chars;
      int          tail_len;
      logic [23:0] type_id;
      int          commas;
      logic [31:0] time_chars;
      logic [47:0] date_chars;
      int          date_len;

      function new(int limit);
         frame_limit = limit;
         in_frame = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         char_count  = 0;
         run_xor     = '0;
         xor_at_star = '0;
         star_seen   = 0;
         cks_chars   = '0;
         tail_len    = 0;
         type_id     = '0;
         commas      = 0;
         time_chars  = '0;
         date_chars  = '0;
         date_len    = 0;
      endfunction

      function int nibble(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
         if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
         if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
         return -1;
      endfunction

      // two ASCII digits to a number, wrapping at 256
      function logic [7:0] pair_value(logic [7:0] a, logic [7:0] b);
         int v;
         v = (int'(a) - 'h30) * 10 + (int'(b) - 'h30);
         return v[7:0];
      endfunction

      function fix_report_type summarize();
         fix_report_type r;
         int          hi;
         int          lo;
         logic [7:0]  sent;
         r  = '0;
         hi = nibble(cks_chars[15:8]);
         lo = nibble(cks_chars[7:0]);
         sent = {hi[3:0], lo[3:0]};
         if (!star_seen || hi < 0 || lo < 0) r.status = nmeafc_pkg::ST_FORMAT;
         else if (xor_at_star != sent)       r.status = nmeafc_pkg::ST_MISMATCH;
         else                                r.status = nmeafc_pkg::ST_OK;
         case (type_id)
            nmeafc_pkg::ID_RMB: r.kind = nmeafc_pkg::KIND_RMB;
            nmeafc_pkg::ID_RMC: r.kind = nmeafc_pkg::KIND_RMC;
            nmeafc_pkg::ID_GGA: r.kind = nmeafc_pkg::KIND_GGA;
            nmeafc_pkg::ID_VTG: r.kind = nmeafc_pkg::KIND_VTG;
            default:            r.kind = nmeafc_pkg::KIND_OTHER;
         endcase
         if (r.status == nmeafc_pkg::ST_OK && r.kind == nmeafc_pkg::KIND_RMC) begin
            if (time_chars[31:24] != nmeafc_pkg::CH_COMMA) begin
               r.time_valid = 1'b1;
               r.hour   = pair_value(time_chars[31:24], time_chars[23:16]);
               r.minute = pair_value(time_chars[15:8], time_chars[7:0]);
            end
            if (commas >= nmeafc_pkg::DATE_COMMAS &&
                date_chars[47:40] != nmeafc_pkg::CH_COMMA) begin
               r.date_valid = 1'b1;
               r.day   = pair_value(date_chars[47:40], date_chars[39:32]);
               r.month = pair_value(date_chars[31:24], date_chars[23:16]);
               r.year  = pair_value(date_chars[15:8], date_chars[7:0]);
            end
         end
         return r;
      endfunction

      function void append(logic [7:0] c);
         int unsigned pos;
         pos = char_count;
         if (c == nmeafc_pkg::CH_STAR) begin
            // a later star discards what followed an earlier one
            star_seen   = 1;
            xor_at_star = run_xor;
            cks_chars   = '0;
            tail_len    = 0;
         end else if (star_seen && tail_len < 2) begin
            if (tail_len == 0) cks_chars[15:8] = c;
            else               cks_chars[7:0]  = c;
            tail_len++;
         end
         run_xor = run_xor ^ c;
         if (pos >= 3 && pos <= 5) type_id = {type_id[15:0], c};
         if (pos >= 7 && pos <= 10) time_chars[8 * (10 - pos) +: 8] = c;
         if (pos >= 7) begin
            if (commas >= nmeafc_pkg::DATE_COMMAS) begin
               if (date_len < 6) begin
                  date_chars[8 * (5 - date_len) +: 8] = c;
                  date_len++;
               end
            end else if (c == nmeafc_pkg::CH_COMMA) begin
               commas++;
            end
         end
         char_count = pos + 1;
         if (char_count >= frame_limit) begin
            in_frame = 0;
            clear_frame();
         end
      endfunction

      // called once per accepted input transfer
      function void take_byte(logic [7:0] c);
         if (in_frame || c == nmeafc_pkg::CH_DOLLAR) counted_bytes++;
         if (!in_frame || c == nmeafc_pkg::CH_DOLLAR) begin
            clear_frame();
            in_frame = (c == nmeafc_pkg::CH_DOLLAR);
            if (in_frame) char_count = 1;
            return;
         end
         if (c == nmeafc_pkg::CH_CR) begin
            if (char_count >= nmeafc_pkg::MIN_CHECK_LEN) begin
               awaited.push_back(summarize());
               reports_made++;
            end else begin
               in_frame = 0;
               clear_frame();
               return;
            end
         end
         append(c);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      // called once per accepted result transfer
      function void check_report(fix_report_type got);
         fix_report_type want;
         if (awaited.size() == 0) begin
            $error("report with none outstanding: status %0d kind %0d",
                   got.status, got.kind);
            errors++;
            return;
         end
         want = awaited.pop_front();
         compare_field("status",        want.status,     got.status);
         compare_field("sentence_kind", want.kind,       got.kind);
         compare_field("time_valid",    want.time_valid, got.time_valid);
         compare_field("hour",          want.hour,       got.hour);
         compare_field("minute",        want.minute,     got.minute);
         compare_field("date_valid",    want.date_valid, got.date_valid);
         compare_field("day",           want.day,        got.day);
         compare_field("month",         want.month,      got.month);
         compare_field("year",          want.year,       got.year);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   send_idle_pct;   // chance in percent that the sender skips a cycle
   int   recv_idle_pct;   // chance in percent that the receiver stalls a cycle

   sentence_tracker tracker;
   logic [7:0]      line_buf[$];   // bytes staged for the next burst

   nmeafc_req_if req_if();
   nmeafc_rsp_if rsp_if();

   nmea_sentence_framer_checker #(
      .MAX_SENTENCE_LEN(FRAME_LIMIT)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   always #1 clock = ~clock;

   // Watchdog; a hang anywhere lands here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Result monitor: every transfer on the result side gets checked
   always @(posedge clock) begin : collect_reports
      fix_report_type seen;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen.status     = rsp_if.status;
         seen.kind       = rsp_if.sentence_kind;
         seen.time_valid = rsp_if.time_valid;
         seen.hour       = rsp_if.hour;
         seen.minute     = rsp_if.minute;
         seen.date_valid = rsp_if.date_valid;
         seen.day        = rsp_if.day;
         seen.month      = rsp_if.month;
         seen.year       = rsp_if.year;
         tracker.check_report(seen);
      end
   end

   // Entered and left at a falling edge. Valid stays high after the
   // transfer so back-to-back bytes need no extra assignment.
   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.rx_byte = b;
      do @(posedge clock); while (!req_if.ready);
      tracker.take_byte(b);
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_byte(line_buf[i]);
      line_buf.delete();
   endtask

   // Pause the sender until the block owes nothing
   task automatic wait_results_drained();
      req_if.valid = 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic void put_digits(int n);
      repeat (n) line_buf.push_back(nmeafc_pkg::CH_ZERO + 8'($urandom_range(9)));
   endfunction

   // any byte that neither reframes, marks a checksum nor ends a line
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == nmeafc_pkg::CH_DOLLAR || c == nmeafc_pkg::CH_STAR ||
             c == nmeafc_pkg::CH_CR);
      return c;
   endfunction

   function automatic void put_field(int n);
      string marks;
      int    r;
      marks = ".NSEWAV-";
      line_buf.push_back(nmeafc_pkg::CH_COMMA);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 70)      line_buf.push_back(nmeafc_pkg::CH_ZERO + 8'($urandom_range(9)));
         else if (r < 85) line_buf.push_back(marks[$urandom_range(marks.len() - 1)]);
         else             line_buf.push_back(plain_byte());
      end
   endfunction

   // Append a checksum tail over everything after the leading '$'
   function automatic void put_checksum(ck_mode_type mode);
      logic [7:0] x;
      string      junk;
      x = '0;
      junk = ":G/g@ ";
      for (int i = 1; i < line_buf.size(); i++) x = x ^ line_buf[i];
      case (mode)
         CK_GOOD:       put_text($sformatf("*%02X", x));
         CK_GOOD_LOWER: put_text($sformatf("*%02x", x));
         CK_WRONG:      put_text($sformatf("*%02X", x ^ (8'h01 << $urandom_range(7))));
         CK_NONE:       ;
         CK_NONHEX: begin
            if ($urandom_range(1)) put_text($sformatf("*%1X", x[7:4]));
            else                   put_text("*");
            line_buf.push_back(junk[$urandom_range(junk.len() - 1)]);
            if (line_buf[line_buf.size() - 2] == nmeafc_pkg::CH_STAR)
               put_text($sformatf("%1X", x[3:0]));
         end
         CK_SHORT:      put_text($sformatf("*%1X", x[7:4]));
         default:       ;
      endcase
   endfunction

   task automatic finish_sentence(ck_mode_type mode);
      put_checksum(mode);
      line_buf.push_back(nmeafc_pkg::CH_CR);
      line_buf.push_back(CH_LF);
      send_line();
   endtask

   task automatic directed_sentences();
      // textbook RMC with time and date
      put_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W");
      finish_sentence(CK_GOOD);
      put_text("$GNRMC,235959,A,1,N,2,E,3,4,311299,,");
      finish_sentence(CK_GOOD_LOWER);
      put_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W");
      finish_sentence(CK_WRONG);
      // empty time and date fields
      put_text("$GPRMC,,V,,,,,,,,,,N");
      finish_sentence(CK_GOOD);
      put_text("$GPRMB,A,0.66,L,003,004,4917.24,N,12309.57,W,001.3,052.5,000.5,V");
      finish_sentence(CK_GOOD);
      put_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,");
      finish_sentence(CK_GOOD);
      put_text("$GPVTG,054.7,T,034.4,M,005.5,N,010.2,K");
      finish_sentence(CK_GOOD);
      // unknown type, and no star at all
      put_text("$GPGSV,3,1,11,03,03,111,00");
      finish_sentence(CK_NONE);
      // several stars: only the last one counts
      put_text("$GPRMC,1*2*3456,A,1,2,3,4,5,6,010203");
      finish_sentence(CK_GOOD);
      put_text("$GPGGA,1,2,3,4,5,6");
      finish_sentence(CK_NONHEX);
      put_text("$GPVTG,1,2,3,4,5");
      finish_sentence(CK_SHORT);
      // noise after a sentence's CR LF, bit patterns at the extremes
      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h80);
      line_buf.push_back(8'h7F);
      // short frames: 8 and 9 chars are dropped at CR, 10 chars report
      put_text("$GPRMC,1");
      line_buf.push_back(nmeafc_pkg::CH_CR);
      put_text("$GPVTG,1,");
      line_buf.push_back(nmeafc_pkg::CH_CR);
      put_text("$GPVTG,1,2");
      line_buf.push_back(nmeafc_pkg::CH_CR);
      send_line();
      // NUL inside the frame and non-digit time chars wrap modulo 256
      put_text("$GPRMC,");
      line_buf.push_back(8'h00);
      put_text("Z:;,A,1,2,3,4,5,6,7,~~0000");
      finish_sentence(CK_GOOD);
      // checksum digits land where time digits are still unreceived
      put_text("$GPRMC,");
      finish_sentence(CK_GOOD);
      // RMC that never reaches the date field
      put_text("$GPRMC,120000,A,1,2");
      finish_sentence(CK_GOOD);
      // '$' mid-frame restarts
      put_text("$GPGGA,12");
      put_text("$GPRMC,0,A,1,2,3,4,5,6,7");
      finish_sentence(CK_GOOD);
      // a second CR reports again over the still open frame
      put_text("$GPRMC,101010,A,1,2,3,4,5,6,101010");
      finish_sentence(CK_GOOD);
      send_byte(nmeafc_pkg::CH_CR);
      // frame closes at the length limit; the CR that follows is ignored
      put_text("$GP");
      repeat (FRAME_LIMIT + 2) line_buf.push_back(8'h41);
      line_buf.push_back(nmeafc_pkg::CH_CR);
      send_line();
   endtask

   // Random sentence body, no checksum yet
   function automatic void build_sentence();
      string ids[6];
      int    r;
      int    middle;
      ids = '{"RMC", "RMC", "RMC", "RMB", "GGA", "VTG"};
      line_buf.push_back(nmeafc_pkg::CH_DOLLAR);
      if ($urandom_range(4) != 0) put_text("GP");
      else repeat (2) line_buf.push_back(8'($urandom_range(8'h5A, 8'h41)));
      if ($urandom_range(6) == 0) repeat (3) line_buf.push_back(8'($urandom_range(8'h5A, 8'h41)));
      else put_text(ids[$urandom_range(5)]);
      if (line_buf[3] == 8'h52 && line_buf[4] == 8'h4D && line_buf[5] == 8'h43) begin
         // time field
         r = $urandom_range(99);
         line_buf.push_back(nmeafc_pkg::CH_COMMA);
         if (r < 60) begin
            put_digits(6);
            if ($urandom_range(1)) put_text(".00");
         end else if (r < 85) begin
            void'(line_buf.pop_back());
            put_field($urandom_range(4, 1));
         end
         // usually seven fields up to the date, sometimes fewer
         middle = ($urandom_range(9) == 0) ? $urandom_range(7, 3) : 7;
         repeat (middle) put_field($urandom_range(4));
         // date field
         r = $urandom_range(99);
         line_buf.push_back(nmeafc_pkg::CH_COMMA);
         if (r < 60) begin
            put_digits(6);
         end else if (r < 85) begin
            void'(line_buf.pop_back());
            put_field($urandom_range(7, 1));
         end
         repeat ($urandom_range(2)) put_field($urandom_range(4));
      end else begin
         repeat ($urandom_range(8, 2)) put_field($urandom_range(5));
      end
      if ($urandom_range(19) == 0)
         line_buf.insert($urandom_range(line_buf.size(), 7), nmeafc_pkg::CH_STAR);
   endfunction

   function automatic ck_mode_type pick_ck_mode();
      int r;
      r = $urandom_range(99);
      if (r < 70) return CK_GOOD;
      if (r < 80) return CK_GOOD_LOWER;
      if (r < 88) return CK_WRONG;
      if (r < 92) return CK_NONE;
      if (r < 96) return CK_NONHEX;
      return CK_SHORT;
   endfunction

   task automatic random_sequence();
      int pick;
      int keep;
      pick = $urandom_range(99);
      if (pick < 80) begin
         build_sentence();
         finish_sentence(pick_ck_mode());
         if ($urandom_range(19) == 0) send_byte(nmeafc_pkg::CH_CR);
      end else if (pick < 88) begin
         // line noise, mostly outside any frame
         repeat ($urandom_range(6, 1)) line_buf.push_back(8'($urandom_range(255)));
         send_line();
      end else if (pick < 95) begin
         // sentence cut short, sometimes ended by a bare CR
         build_sentence();
         keep = $urandom_range(line_buf.size() - 1, 1);
         while (line_buf.size() > keep) void'(line_buf.pop_back());
         if ($urandom_range(1)) line_buf.push_back(nmeafc_pkg::CH_CR);
         send_line();
      end else if (pick < 98) begin
         line_buf.push_back(nmeafc_pkg::CH_DOLLAR);
         repeat ($urandom_range(8)) line_buf.push_back(plain_byte());
         line_buf.push_back(nmeafc_pkg::CH_CR);
         send_line();
      end else begin
         // long frame, which may run into the length limit
         line_buf.push_back(nmeafc_pkg::CH_DOLLAR);
         repeat ($urandom_range(FRAME_LIMIT + 12, FRAME_LIMIT - 8)) line_buf.push_back(plain_byte());
         line_buf.push_back(nmeafc_pkg::CH_CR);
         send_line();
      end
   endtask

   task automatic run_random(int byte_goal, int report_goal);
      int byte_base;
      int report_base;
      byte_base   = tracker.counted_bytes;
      report_base = tracker.reports_made;
      while (tracker.counted_bytes - byte_base < byte_goal ||
             tracker.reports_made - report_base < report_goal)
         random_sequence();
   endtask

   initial begin
      tracker        = new(FRAME_LIMIT);
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      send_idle_pct  = 34;
      recv_idle_pct  = 62;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_sentences();

      // phase 1: sender gappy, receiver stalls often
      run_random(90, 0);
      wait_results_drained();
      // phase 2: roles swapped
      send_idle_pct = 62;
      recv_idle_pct = 34;
      run_random(90, 0);
      wait_results_drained();
      // phase 3: full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(90, 0);
      wait_results_drained();

      // let any late, unexpected report show up
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
